FILE: src/rhc_pkg.sv
// Shared types, constants and helper functions for the RGB565 HSV classifier.
`default_nettype none
package rhc_pkg;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_A_HUE = 3'd0,
		REG_A_SAT = 3'd1,
		REG_A_VAL = 3'd2,
		REG_B_HUE = 3'd3,
		REG_B_SAT = 3'd4,
		REG_B_VAL = 3'd5
	} reg_idx_t;

	// Result class codes
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_A    = 2'd1,
		CLS_B    = 2'd2
	} class_t;

	// Which channel holds the maximum
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Inclusive byte range: high byte maximum, low byte minimum
	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
	} range_t;

	typedef struct packed {
		range_t hue;
		range_t sat;
		range_t val;
	} box_t;

	localparam box_t BOX_A_RST = '{
		hue: '{hi: 8'h20, lo: 8'h12},
		sat: '{hi: 8'hFF, lo: 8'hBE},
		val: '{hi: 8'hFF, lo: 8'h5A}
	};
	localparam box_t BOX_B_RST = '{
		hue: '{hi: 8'h30, lo: 8'h1C},
		sat: '{hi: 8'hC8, lo: 8'h82},
		val: '{hi: 8'hFF, lo: 8'h2D}
	};

	// Hue offsets in half degrees
	localparam logic [7:0] HUE_GREEN_BASE = 8'd60;
	localparam logic [7:0] HUE_BLUE_BASE  = 8'd120;
	localparam logic [7:0] HUE_WRAP       = 8'd180;

	// Divider: 8 quotient bits, two per pipeline stage
	localparam int QUOT_BITS  = 8;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;

	// Word handed from the front end through the divider stages
	typedef struct packed {
		logic [15:0] sat_acc;  // {remainder, numerator / quotient}
		logic [15:0] hue_acc;
		logic [7:0]  mx;
		logic [7:0]  delta;
		sector_t     sector;
		logic        neg;      // sector difference is negative
	} div_t;

	// Channel widening tables: c*255/31 and c*255/63, truncated
	typedef logic [7:0] lut5_t [32];
	typedef logic [7:0] lut6_t [64];

	function automatic lut5_t build_lut5();
		lut5_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255) / 31);
		end
		return t;
	endfunction

	function automatic lut6_t build_lut6();
		lut6_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255) / 63);
		end
		return t;
	endfunction

	localparam lut5_t LUT5 = build_lut5();
	localparam lut6_t LUT6 = build_lut6();

	// One restoring shift-subtract step; quotient bit enters at the bottom
	function automatic logic [15:0] div_step(input logic [15:0] acc, input logic [7:0] d);
		logic [8:0] trial;
		logic [8:0] rem;
		logic [15:0] res;
		trial = acc[15:7];
		rem   = trial - {1'b0, d};
		if (trial >= {1'b0, d}) begin
			res = {rem[7:0], acc[6:0], 1'b1};
		end else begin
			res = {trial[7:0], acc[6:0], 1'b0};
		end
		return res;
	endfunction

	function automatic logic in_range(input logic [7:0] v, input range_t r);
		return (v >= r.lo) && (v <= r.hi);
	endfunction

endpackage
`default_nettype wire

FILE: src/rgb565_hsv_dual_threshold_classifier_unit.sv
// Top level: configuration registers and the classifier pipeline.
//
//   channel  signals                         direction  word
//   pixel    pix_valid/pix_ready             in         pixel_rgb565
//   result   res_valid/res_ready             out        class_code, hue, saturation, brightness
//   config   cfg_we, cfg_addr, cfg_data      in         one 16-bit range register
//
// One pixel per clock sustained while res_ready stays high; 3 front-end stages,
// 4 divider stages of 2 quotient bits each, 2 back-end stages.
// The divider stages compute 255*delta/max and 30*diff/delta side by side.
// Reset clears all valid bits and loads the default ranges.
// A stall on res_ready holds each full stage; empty stages still fill, so
// pix_ready drops only when every stage holds a word.
`default_nettype none
module rgb565_hsv_dual_threshold_classifier_unit import rhc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] pixel_rgb565,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	output logic [1:0]       class_code,
	output logic [7:0]       hue,
	output logic [7:0]       saturation,
	output logic [7:0]       brightness,
	output logic             res_valid,
	input  wire logic        res_ready,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_data
);

	box_t box_a_q, box_b_q;

	// range registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_a_q <= BOX_A_RST;
			box_b_q <= BOX_B_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_A_HUE: box_a_q.hue <= cfg_data;
				REG_A_SAT: box_a_q.sat <= cfg_data;
				REG_A_VAL: box_a_q.val <= cfg_data;
				REG_B_HUE: box_b_q.hue <= cfg_data;
				REG_B_SAT: box_b_q.sat <= cfg_data;
				REG_B_VAL: box_b_q.val <= cfg_data;
				default: ;
			endcase
		end
	end

	div_t data  [DIV_STAGES+1];
	logic valid [DIV_STAGES+1];
	logic ready [DIV_STAGES+1];

	rhc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_rgb565 (pixel_rgb565),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.dout         (data[0]),
		.dout_valid   (valid[0]),
		.dout_ready   (ready[0])
	);

	// divider pipeline
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		rhc_div_stage u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.din        (data[i]),
			.din_valid  (valid[i]),
			.din_ready  (ready[i]),
			.dout       (data[i+1]),
			.dout_valid (valid[i+1]),
			.dout_ready (ready[i+1])
		);
	end

	rhc_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (data[DIV_STAGES]),
		.din_valid  (valid[DIV_STAGES]),
		.din_ready  (ready[DIV_STAGES]),
		.box_a      (box_a_q),
		.box_b      (box_b_q),
		.class_code (class_code),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

endmodule
`default_nettype wire

FILE: src/rhc_front.sv
// Front end: channel widening, max/min search and divider numerators (three stages).
`default_nettype none
module rhc_front import rhc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] pixel_rgb565,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	output div_t             dout,
	output logic             dout_valid,
	input  wire logic        dout_ready
);

	logic       v_s1, v_s2, v_s3;
	logic       rdy1, rdy2, rdy3;
	logic [7:0] r_s1, g_s1, b_s1;
	logic [7:0] mx_s2, mn_s2, p_s2, q_s2;
	sector_t    sec_s2;
	div_t       data_s3;

	// stage handshake: a stage loads when empty or when its word moves on
	assign rdy3      = !v_s3 || dout_ready;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pix_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// s1: widen channels to 8 bits
	always_ff @(posedge clk) begin
		if (pix_valid && rdy1) begin
			r_s1 <= LUT5[pixel_rgb565[15:11]];
			g_s1 <= LUT6[pixel_rgb565[10:5]];
			b_s1 <= LUT5[pixel_rgb565[4:0]];
		end
	end

	// s2: max, min and sector operands; red wins ties, then green
	logic       red_max, green_max;
	logic [7:0] mn_c;

	always_comb begin
		red_max   = (r_s1 >= g_s1) && (r_s1 >= b_s1);
		green_max = !red_max && (g_s1 >= b_s1);
		mn_c      = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			mn_s2 <= mn_c;
			if (red_max) begin
				mx_s2  <= r_s1;
				p_s2   <= g_s1;
				q_s2   <= b_s1;
				sec_s2 <= SEC_RED;
			end else if (green_max) begin
				mx_s2  <= g_s1;
				p_s2   <= b_s1;
				q_s2   <= r_s1;
				sec_s2 <= SEC_GREEN;
			end else begin
				mx_s2  <= b_s1;
				p_s2   <= r_s1;
				q_s2   <= g_s1;
				sec_s2 <= SEC_BLUE;
			end
		end
	end

	// s3: delta, |p-q| and the numerators 255*delta and 30*diff
	logic [7:0]  delta_c, diff_c;
	logic        neg_c;
	logic [15:0] sat_num_c, hue_num_c;

	always_comb begin
		delta_c   = mx_s2 - mn_s2;
		neg_c     = p_s2 < q_s2;
		diff_c    = neg_c ? (q_s2 - p_s2) : (p_s2 - q_s2);
		sat_num_c = {delta_c, 8'd0} - {8'd0, delta_c};
		hue_num_c = {3'd0, diff_c, 5'd0} - {7'd0, diff_c, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			data_s3.sat_acc <= sat_num_c;
			data_s3.hue_acc <= hue_num_c;
			data_s3.mx      <= mx_s2;
			data_s3.delta   <= delta_c;
			data_s3.sector  <= sec_s2;
			data_s3.neg     <= neg_c;
		end
	end

	assign dout       = data_s3;
	assign dout_valid = v_s3;

endmodule
`default_nettype wire

FILE: src/rhc_div_stage.sv
// One divider stage: two shift-subtract steps for both the saturation and hue quotients.
`default_nettype none
module rhc_div_stage import rhc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire div_t din,
	input  wire logic din_valid,
	output logic      din_ready,
	output div_t      dout,
	output logic      dout_valid,
	input  wire logic dout_ready
);

	logic v_s1;
	div_t data_s1;
	div_t next_c;

	assign din_ready = !v_s1 || dout_ready;

	// saturation divides by max, hue by delta
	always_comb begin
		next_c = din;
		for (int i = 0; i < DIV_STEPS; i++) begin
			next_c.sat_acc = div_step(next_c.sat_acc, din.mx);
			next_c.hue_acc = div_step(next_c.hue_acc, din.delta);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din_ready) begin
			v_s1 <= din_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din_valid && din_ready) begin
			data_s1 <= next_c;
		end
	end

	assign dout       = data_s1;
	assign dout_valid = v_s1;

	// partial remainders stay below their divisors
	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && data_s1.mx != 8'd0 |-> data_s1.sat_acc[15:8] < data_s1.mx)
		else $error("saturation remainder not below max");

	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && data_s1.delta != 8'd0 |-> data_s1.hue_acc[15:8] < data_s1.delta)
		else $error("hue remainder not below delta");

endmodule
`default_nettype wire

FILE: src/rhc_classify.sv
// Back end: hue/saturation finish, box tests and the output register (two stages).
`default_nettype none
module rhc_classify import rhc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire div_t  din,
	input  wire logic  din_valid,
	output logic       din_ready,
	input  wire box_t  box_a,
	input  wire box_t  box_b,
	output logic [1:0] class_code,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [7:0] brightness,
	output logic       res_valid,
	input  wire logic  res_ready
);

	logic       v_s1, v_s2;
	logic       rdy1, rdy2;
	logic [7:0] hue_s1, sat_s1, val_s1;
	logic [7:0] hue_s2, sat_s2, val_s2;
	class_t     cls_s2;

	assign rdy2      = !v_s2 || res_ready;
	assign rdy1      = !v_s1 || rdy2;
	assign din_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= din_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	// s1: sector offset, grey and black pixels
	logic [7:0] q_hue;
	logic [7:0] hue_c;

	always_comb begin
		q_hue = din.hue_acc[7:0];
		unique case (din.sector)
			SEC_RED:   hue_c = din.neg ? (HUE_WRAP - q_hue) : q_hue;
			SEC_GREEN: hue_c = din.neg ? (HUE_GREEN_BASE - q_hue) : (HUE_GREEN_BASE + q_hue);
			SEC_BLUE:  hue_c = din.neg ? (HUE_BLUE_BASE - q_hue) : (HUE_BLUE_BASE + q_hue);
			default:   hue_c = 8'd0;
		endcase
		if (din.delta == 8'd0) hue_c = 8'd0;
	end

	always_ff @(posedge clk) begin
		if (din_valid && rdy1) begin
			hue_s1 <= hue_c;
			sat_s1 <= (din.mx == 8'd0) ? 8'd0 : din.sat_acc[7:0];
			val_s1 <= din.mx;
		end
	end

	// s2: box tests, box A first
	logic match_a, match_b;

	always_comb begin
		match_a = in_range(hue_s1, box_a.hue) && in_range(sat_s1, box_a.sat)
			&& in_range(val_s1, box_a.val);
		match_b = in_range(hue_s1, box_b.hue) && in_range(sat_s1, box_b.sat)
			&& in_range(val_s1, box_b.val);
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			hue_s2 <= hue_s1;
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
			priority if (match_a) begin
				cls_s2 <= CLS_A;
			end else if (match_b) begin
				cls_s2 <= CLS_B;
			end else begin
				cls_s2 <= CLS_NONE;
			end
		end
	end

	assign class_code = cls_s2;
	assign hue        = hue_s2;
	assign saturation = sat_s2;
	assign brightness = val_s2;
	assign res_valid  = v_s2;

	a_hue_span: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> hue <= HUE_WRAP)
		else $error("hue beyond 180");

	// a colored pixel has nonzero saturation and brightness
	a_hue_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && hue != 8'd0 |-> saturation != 8'd0 && brightness != 8'd0)
		else $error("hue set on a grey pixel");

endmodule
`default_nettype wire
